@@ rtl/aate_pkg.sv @@
// Shared types, constants and helpers for the axis-angle to Euler converter.
package aate_pkg;

   localparam int CORDIC_ITERATIONS = 16;

   typedef logic signed [31:0] vec_type;   // Q.30 vector component
   typedef logic signed [35:0] wide_type;  // CORDIC working value
   typedef logic signed [33:0] zacc_type;  // sine/cosine residual angle
   typedef logic signed [63:0] prod_type;  // full product
   typedef logic [31:0]        ang_type;   // binary angle, 2^32 per turn

   localparam ang_type QUARTER       = 32'h4000_0000;
   localparam ang_type THREE_QUARTER = 32'hC000_0000;
   localparam ang_type EIGHTH        = 32'h2000_0000;
   localparam vec_type ONE_Q         = 32'sh4000_0000;
   localparam wide_type CORDIC_K     = 36'sd652032874;
   localparam logic signed [64:0] ROUND_HALF = 65'sd536870912;

   localparam ang_type ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Working set that travels down the pipeline with each item
   typedef struct packed {
      vec_type ax, ay, az;
      vec_type xa, xb, xc;
      vec_type ya, yb, yc;
      ang_type turn, zr, yr;
      vec_type cosn1, sinn1, cost, sint, cosn2, sinn2;
   } ctx_type;

   // True when |v| lies below the dead zone (Q0.15 threshold scaled to Q.30)
   function automatic logic in_zone(input vec_type v, input logic [14:0] dz);
      wide_type thr;
      wide_type w;
      thr = {6'b0, dz, 15'b0};
      w   = 36'(v);
      return (w > -thr) && (w < thr);
   endfunction

   function automatic vec_type zoned(input vec_type v, input logic [14:0] dz);
      return in_zone(v, dz) ? '0 : v;
   endfunction

endpackage

@@ rtl/axis_angle_to_euler_xyz.sv @@
// Top level: axis-angle to XYZ Euler angle converter, fully pipelined.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   axis_x, axis_y, axis_z, turn_angle
//   rsp      out        rsp_tvalid/rsp_tready   euler_x, euler_y, euler_z
//   csr      in         csr_wr_en               dead_zone
//
// One item enters per cycle while rsp is not stalled; the pipeline is built from
// five vectoring and four sine/cosine CORDIC chains of one stage per step.
// A stall on rsp holds every stage at once; nothing is lost or repeated.
// Reset clears all valid bits and sets dead_zone to 1.
module axis_angle_to_euler_xyz import aate_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // axis_x, axis_y, axis_z, turn_angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // euler_x, euler_y, euler_z
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data  // dead_zone
);

   logic        advance;
   logic [14:0] dead_zone_ff;
   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;

   ctx_type ctx0;
   logic    v1_valid, s1_valid, r1_valid, v2_valid, s2_valid, r2_valid, r3_valid;
   logic    r4_valid, r5_valid, v3_valid, s3_valid, r6_valid, v4_valid, s4_valid;
   logic    r7_valid, v5_valid;
   ctx_type v1_ctx, s1_ctx, r1_ctx, v2_ctx, s2_ctx, r2_ctx, r3_ctx, r4_ctx, r5_ctx;
   ctx_type v3_ctx, s3_ctx, r6_ctx, v4_ctx, s4_ctx, r7_ctx, v5_ctx;
   ctx_type s1_in_ctx, r1_in_ctx, v2_in_ctx, r2_in_ctx, r3_in_ctx, r4_in_ctx, r5_in_ctx;
   ctx_type v3_in_ctx, s3_in_ctx, r6_in_ctx, v4_in_ctx, s4_in_ctx, r7_in_ctx, v5_in_ctx;
   ang_type v1_ang, v2_ang, v3_ang, v4_ang, v5_ang;
   ang_type s1_ang [3], s2_ang [3], s3_ang [3], s4_ang [3];
   vec_type s1_cos [3], s1_sin [3], s2_cos [3], s2_sin [3];
   vec_type s3_cos [3], s3_sin [3], s4_cos [3], s4_sin [3];
   vec_type r1_p [3], r1_q [3], r2_p [3], r2_q [3], r3_p [3], r3_q [3];
   vec_type r4_p [3], r4_q [3], r5_p [3], r5_q [3], r6_p [3], r6_q [3];
   vec_type r7_p [3], r7_q [3];
   vec_type r1_po [3], r1_qo [3], r2_po [3], r2_qo [3], r3_po [3], r3_qo [3];
   vec_type r4_po [3], r4_qo [3], r5_po [3], r5_qo [3], r6_po [3], r6_qo [3];
   vec_type r7_po [3], r7_qo [3];
   logic [31:0] ex_sum, ey_sum, ez_sum;

   // Advance every stage unless a finished result is held
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= 15'd1;
      end else if (csr_wr_en) begin
         dead_zone_ff <= csr_wr_data;
      end
   end

   // Unpack the transfer and seed the unit X and Y vectors
   always_comb begin
      ctx0       = '0;
      ctx0.ax    = {req_tdata[15], req_tdata[15:0], 15'b0};
      ctx0.ay    = {req_tdata[31], req_tdata[31:16], 15'b0};
      ctx0.az    = {req_tdata[47], req_tdata[47:32], 15'b0};
      ctx0.turn  = {req_tdata[63:48], 16'b0};
      ctx0.xa    = ONE_Q;
      ctx0.yb    = ONE_Q;
   end

   // r1: bring the axis into the XY plane
   aate_vec u_v1 (
      .clock, .reset, .advance, .in_valid(req_tvalid), .in_ctx(ctx0),
      .rise(ctx0.az), .run(ctx0.ay), .force_zero(in_zone(ctx0.az, dead_zone_ff)),
      .out_valid(v1_valid), .out_ctx(v1_ctx), .angle(v1_ang)
   );

   always_comb begin
      s1_in_ctx = v1_ctx;
      s1_ang[0] = v1_ang;
      s1_ang[1] = 32'd0 - v1_ang;
      s1_ang[2] = v1_ctx.turn;
   end

   aate_sc u_s1 (
      .clock, .reset, .advance, .in_valid(v1_valid), .in_ctx(s1_in_ctx),
      .angle_in(s1_ang), .out_valid(s1_valid), .out_ctx(s1_ctx),
      .cos_out(s1_cos), .sin_out(s1_sin)
   );

   always_comb begin
      r1_in_ctx       = s1_ctx;
      r1_in_ctx.cosn1 = s1_cos[1];
      r1_in_ctx.sinn1 = s1_sin[1];
      r1_in_ctx.cost  = s1_cos[2];
      r1_in_ctx.sint  = s1_sin[2];
      r1_p[0] = s1_ctx.ay;  r1_q[0] = s1_ctx.az;
      r1_p[1] = s1_ctx.xb;  r1_q[1] = s1_ctx.xc;
      r1_p[2] = s1_ctx.yb;  r1_q[2] = s1_ctx.yc;
   end

   aate_rot u_r1 (
      .clock, .reset, .advance, .in_valid(s1_valid), .in_ctx(r1_in_ctx),
      .p_in(r1_p), .q_in(r1_q), .cos_in(s1_cos[0]), .sin_in(s1_sin[0]),
      .out_valid(r1_valid), .out_ctx(r1_ctx), .p_out(r1_po), .q_out(r1_qo)
   );

   always_comb begin
      v2_in_ctx    = r1_ctx;
      v2_in_ctx.ay = r1_po[0];
      v2_in_ctx.az = r1_qo[0];
      v2_in_ctx.xb = r1_po[1];
      v2_in_ctx.xc = r1_qo[1];
      v2_in_ctx.yb = r1_po[2];
      v2_in_ctx.yc = r1_qo[2];
   end

   // r2: bring the axis onto Y
   aate_vec u_v2 (
      .clock, .reset, .advance, .in_valid(r1_valid), .in_ctx(v2_in_ctx),
      .rise(v2_in_ctx.ax), .run(v2_in_ctx.ay),
      .force_zero(in_zone(v2_in_ctx.ax, dead_zone_ff)),
      .out_valid(v2_valid), .out_ctx(v2_ctx), .angle(v2_ang)
   );

   always_comb begin
      s2_ang[0] = v2_ang;
      s2_ang[1] = 32'd0 - v2_ang;
      s2_ang[2] = '0;
   end

   aate_sc u_s2 (
      .clock, .reset, .advance, .in_valid(v2_valid), .in_ctx(v2_ctx),
      .angle_in(s2_ang), .out_valid(s2_valid), .out_ctx(s2_ctx),
      .cos_out(s2_cos), .sin_out(s2_sin)
   );

   always_comb begin
      r2_in_ctx       = s2_ctx;
      r2_in_ctx.cosn2 = s2_cos[1];
      r2_in_ctx.sinn2 = s2_sin[1];
      r2_p[0] = s2_ctx.xb;  r2_q[0] = s2_ctx.xa;
      r2_p[1] = s2_ctx.yb;  r2_q[1] = s2_ctx.ya;
      r2_p[2] = '0;         r2_q[2] = '0;
   end

   aate_rot u_r2 (
      .clock, .reset, .advance, .in_valid(s2_valid), .in_ctx(r2_in_ctx),
      .p_in(r2_p), .q_in(r2_q), .cos_in(s2_cos[0]), .sin_in(s2_sin[0]),
      .out_valid(r2_valid), .out_ctx(r2_ctx), .p_out(r2_po), .q_out(r2_qo)
   );

   // Turn about Y
   always_comb begin
      r3_in_ctx    = r2_ctx;
      r3_in_ctx.xb = r2_po[0];
      r3_in_ctx.xa = r2_qo[0];
      r3_in_ctx.yb = r2_po[1];
      r3_in_ctx.ya = r2_qo[1];
      r3_p[0] = r3_in_ctx.xa;  r3_q[0] = r3_in_ctx.xc;
      r3_p[1] = r3_in_ctx.ya;  r3_q[1] = r3_in_ctx.yc;
      r3_p[2] = '0;            r3_q[2] = '0;
   end

   aate_rot u_r3 (
      .clock, .reset, .advance, .in_valid(r2_valid), .in_ctx(r3_in_ctx),
      .p_in(r3_p), .q_in(r3_q), .cos_in(r3_in_ctx.cost), .sin_in(r3_in_ctx.sint),
      .out_valid(r3_valid), .out_ctx(r3_ctx), .p_out(r3_po), .q_out(r3_qo)
   );

   // Undo r2
   always_comb begin
      r4_in_ctx    = r3_ctx;
      r4_in_ctx.xa = r3_po[0];
      r4_in_ctx.xc = r3_qo[0];
      r4_in_ctx.ya = r3_po[1];
      r4_in_ctx.yc = r3_qo[1];
      r4_p[0] = r4_in_ctx.xb;  r4_q[0] = r4_in_ctx.xa;
      r4_p[1] = r4_in_ctx.yb;  r4_q[1] = r4_in_ctx.ya;
      r4_p[2] = '0;            r4_q[2] = '0;
   end

   aate_rot u_r4 (
      .clock, .reset, .advance, .in_valid(r3_valid), .in_ctx(r4_in_ctx),
      .p_in(r4_p), .q_in(r4_q), .cos_in(r4_in_ctx.cosn2), .sin_in(r4_in_ctx.sinn2),
      .out_valid(r4_valid), .out_ctx(r4_ctx), .p_out(r4_po), .q_out(r4_qo)
   );

   // Undo r1
   always_comb begin
      r5_in_ctx    = r4_ctx;
      r5_in_ctx.xb = r4_po[0];
      r5_in_ctx.xa = r4_qo[0];
      r5_in_ctx.yb = r4_po[1];
      r5_in_ctx.ya = r4_qo[1];
      r5_p[0] = r5_in_ctx.xb;  r5_q[0] = r5_in_ctx.xc;
      r5_p[1] = r5_in_ctx.yb;  r5_q[1] = r5_in_ctx.yc;
      r5_p[2] = '0;            r5_q[2] = '0;
   end

   aate_rot u_r5 (
      .clock, .reset, .advance, .in_valid(r4_valid), .in_ctx(r5_in_ctx),
      .p_in(r5_p), .q_in(r5_q), .cos_in(r5_in_ctx.cosn1), .sin_in(r5_in_ctx.sinn1),
      .out_valid(r5_valid), .out_ctx(r5_ctx), .p_out(r5_po), .q_out(r5_qo)
   );

   always_comb begin
      v3_in_ctx    = r5_ctx;
      v3_in_ctx.xb = r5_po[0];
      v3_in_ctx.xc = r5_qo[0];
      v3_in_ctx.yb = r5_po[1];
      v3_in_ctx.yc = r5_qo[1];
   end

   // Zr from the rotated X vector
   aate_vec u_v3 (
      .clock, .reset, .advance, .in_valid(r5_valid), .in_ctx(v3_in_ctx),
      .rise(zoned(v3_in_ctx.xb, dead_zone_ff)), .run(zoned(v3_in_ctx.xa, dead_zone_ff)),
      .force_zero(1'b0),
      .out_valid(v3_valid), .out_ctx(v3_ctx), .angle(v3_ang)
   );

   always_comb begin
      s3_in_ctx    = v3_ctx;
      s3_in_ctx.zr = v3_ang;
      s3_ang[0]    = v3_ang;
      s3_ang[1]    = '0;
      s3_ang[2]    = '0;
   end

   aate_sc u_s3 (
      .clock, .reset, .advance, .in_valid(v3_valid), .in_ctx(s3_in_ctx),
      .angle_in(s3_ang), .out_valid(s3_valid), .out_ctx(s3_ctx),
      .cos_out(s3_cos), .sin_out(s3_sin)
   );

   always_comb begin
      r6_in_ctx = s3_ctx;
      r6_p[0] = s3_ctx.xa;  r6_q[0] = s3_ctx.xb;
      r6_p[1] = s3_ctx.ya;  r6_q[1] = s3_ctx.yb;
      r6_p[2] = '0;         r6_q[2] = '0;
   end

   aate_rot u_r6 (
      .clock, .reset, .advance, .in_valid(s3_valid), .in_ctx(r6_in_ctx),
      .p_in(r6_p), .q_in(r6_q), .cos_in(s3_cos[0]), .sin_in(s3_sin[0]),
      .out_valid(r6_valid), .out_ctx(r6_ctx), .p_out(r6_po), .q_out(r6_qo)
   );

   always_comb begin
      v4_in_ctx    = r6_ctx;
      v4_in_ctx.xa = r6_po[0];
      v4_in_ctx.xb = r6_qo[0];
      v4_in_ctx.ya = r6_po[1];
      v4_in_ctx.yb = r6_qo[1];
   end

   // Yr
   aate_vec u_v4 (
      .clock, .reset, .advance, .in_valid(r6_valid), .in_ctx(v4_in_ctx),
      .rise(zoned(v4_in_ctx.xc, dead_zone_ff)), .run(zoned(v4_in_ctx.xa, dead_zone_ff)),
      .force_zero(1'b0),
      .out_valid(v4_valid), .out_ctx(v4_ctx), .angle(v4_ang)
   );

   always_comb begin
      s4_in_ctx    = v4_ctx;
      s4_in_ctx.yr = v4_ang;
      s4_ang[0]    = v4_ang;
      s4_ang[1]    = '0;
      s4_ang[2]    = '0;
   end

   aate_sc u_s4 (
      .clock, .reset, .advance, .in_valid(v4_valid), .in_ctx(s4_in_ctx),
      .angle_in(s4_ang), .out_valid(s4_valid), .out_ctx(s4_ctx),
      .cos_out(s4_cos), .sin_out(s4_sin)
   );

   always_comb begin
      r7_in_ctx = s4_ctx;
      r7_p[0] = s4_ctx.xa;  r7_q[0] = s4_ctx.xc;
      r7_p[1] = s4_ctx.ya;  r7_q[1] = s4_ctx.yc;
      r7_p[2] = '0;         r7_q[2] = '0;
   end

   aate_rot u_r7 (
      .clock, .reset, .advance, .in_valid(s4_valid), .in_ctx(r7_in_ctx),
      .p_in(r7_p), .q_in(r7_q), .cos_in(s4_cos[0]), .sin_in(s4_sin[0]),
      .out_valid(r7_valid), .out_ctx(r7_ctx), .p_out(r7_po), .q_out(r7_qo)
   );

   always_comb begin
      v5_in_ctx    = r7_ctx;
      v5_in_ctx.xa = r7_po[0];
      v5_in_ctx.xc = r7_qo[0];
      v5_in_ctx.ya = r7_po[1];
      v5_in_ctx.yc = r7_qo[1];
   end

   // Xr from the rotated Y vector
   aate_vec u_v5 (
      .clock, .reset, .advance, .in_valid(r7_valid), .in_ctx(v5_in_ctx),
      .rise(zoned(v5_in_ctx.yc, dead_zone_ff)), .run(zoned(v5_in_ctx.yb, dead_zone_ff)),
      .force_zero(1'b0),
      .out_valid(v5_valid), .out_ctx(v5_ctx), .angle(v5_ang)
   );

   // Round the angles to 16 bits and hold the result for transfer
   assign ex_sum = v5_ang + 32'h0000_8000;
   assign ey_sum = v5_ctx.yr + 32'h0000_8000;
   assign ez_sum = v5_ctx.zr + 32'h0000_8000;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v5_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {ez_sum[31:16], ey_sum[31:16], ex_sum[31:16]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(v5_valid))
      else $error("pipeline moved while result was held");

   a_ready_when_empty : assert property (@(posedge clock) !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

endmodule

@@ rtl/aate_vec.sv @@
// Pipelined vectoring CORDIC: atan2(rise, run) as a binary angle.
module aate_vec import aate_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  ctx_type in_ctx,
   input  vec_type rise,
   input  vec_type run,
   input  logic    force_zero,
   output logic    out_valid,
   output ctx_type out_ctx,
   output ang_type angle
);

   logic     valid_ff [CORDIC_ITERATIONS+1];
   ctx_type  ctx_ff   [CORDIC_ITERATIONS+1];
   wide_type x_ff     [CORDIC_ITERATIONS+1];
   wide_type y_ff     [CORDIC_ITERATIONS+1];
   ang_type  z_ff     [CORDIC_ITERATIONS+1];
   logic     zero_ff  [CORDIC_ITERATIONS+1];

   wide_type x_in, y_in, rx, ry;
   ang_type  z_in;
   logic     zero_in;

   // Fold the left half plane onto the right one
   always_comb begin
      rx      = 36'(run);
      ry      = 36'(rise);
      x_in    = rx;
      y_in    = ry;
      z_in    = '0;
      zero_in = force_zero || (run == '0 && rise == '0);
      if (rx < 0) begin
         if (ry >= 0) begin
            x_in = ry;
            y_in = -rx;
            z_in = QUARTER;
         end else begin
            x_in = -ry;
            y_in = rx;
            z_in = THREE_QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx_ff[0]  <= in_ctx;
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
         zero_ff[0] <= zero_in;
      end
   end

   // One micro-rotation per stage
   for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_step
      wide_type sx_in, sy_in;
      ang_type  sz_in;

      always_comb begin
         if (y_ff[i] >= 0) begin
            sx_in = x_ff[i] + (y_ff[i] >>> i);
            sy_in = y_ff[i] - (x_ff[i] >>> i);
            sz_in = z_ff[i] + ATAN_TAB[i];
         end else begin
            sx_in = x_ff[i] - (y_ff[i] >>> i);
            sy_in = y_ff[i] + (x_ff[i] >>> i);
            sz_in = z_ff[i] - ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            ctx_ff[i+1]  <= ctx_ff[i];
            x_ff[i+1]    <= sx_in;
            y_ff[i+1]    <= sy_in;
            z_ff[i+1]    <= sz_in;
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[CORDIC_ITERATIONS];
   assign out_ctx   = ctx_ff[CORDIC_ITERATIONS];
   assign angle     = zero_ff[CORDIC_ITERATIONS] ? '0 : z_ff[CORDIC_ITERATIONS];

endmodule

@@ rtl/aate_sc.sv @@
// Pipelined rotation-mode CORDIC: cosine and sine of three angles side by side.
module aate_sc import aate_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  ctx_type in_ctx,
   input  ang_type angle_in [3],
   output logic    out_valid,
   output ctx_type out_ctx,
   output vec_type cos_out [3],
   output vec_type sin_out [3]
);

   logic     valid_ff [CORDIC_ITERATIONS+1];
   ctx_type  ctx_ff   [CORDIC_ITERATIONS+1];
   wide_type x_ff     [CORDIC_ITERATIONS+1][3];
   wide_type y_ff     [CORDIC_ITERATIONS+1][3];
   zacc_type z_ff     [CORDIC_ITERATIONS+1][3];
   logic [1:0] q_ff   [CORDIC_ITERATIONS+1][3];

   logic [1:0] q_in [3];
   zacc_type   z_in [3];

   // Pull each angle into the quarter turn around zero
   always_comb begin
      ang_type sum;
      ang_type d;
      for (int k = 0; k < 3; k++) begin
         sum     = angle_in[k] + EIGHTH;
         q_in[k] = sum[31:30];
         d       = angle_in[k] - {q_in[k], 30'b0};
         z_in[k] = 34'(signed'(d));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx_ff[0] <= in_ctx;
         for (int k = 0; k < 3; k++) begin
            x_ff[0][k] <= CORDIC_K;
            y_ff[0][k] <= '0;
            z_ff[0][k] <= z_in[k];
            q_ff[0][k] <= q_in[k];
         end
      end
   end

   for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_step
      wide_type sx_in [3];
      wide_type sy_in [3];
      zacc_type sz_in [3];

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            if (z_ff[i][k] >= 0) begin
               sx_in[k] = x_ff[i][k] - (y_ff[i][k] >>> i);
               sy_in[k] = y_ff[i][k] + (x_ff[i][k] >>> i);
               sz_in[k] = z_ff[i][k] - $signed({2'b0, ATAN_TAB[i]});
            end else begin
               sx_in[k] = x_ff[i][k] + (y_ff[i][k] >>> i);
               sy_in[k] = y_ff[i][k] - (x_ff[i][k] >>> i);
               sz_in[k] = z_ff[i][k] + $signed({2'b0, ATAN_TAB[i]});
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            ctx_ff[i+1] <= ctx_ff[i];
            for (int k = 0; k < 3; k++) begin
               x_ff[i+1][k] <= sx_in[k];
               y_ff[i+1][k] <= sy_in[k];
               z_ff[i+1][k] <= sz_in[k];
               q_ff[i+1][k] <= q_ff[i][k];
            end
         end
      end
   end

   // Map the result back to its quadrant
   always_comb begin
      wide_type xl, yl, c, s;
      for (int k = 0; k < 3; k++) begin
         xl = x_ff[CORDIC_ITERATIONS][k];
         yl = y_ff[CORDIC_ITERATIONS][k];
         unique case (q_ff[CORDIC_ITERATIONS][k])
            2'd0: begin c = xl;  s = yl;  end
            2'd1: begin c = -yl; s = xl;  end
            2'd2: begin c = -xl; s = -yl; end
            2'd3: begin c = yl;  s = -xl; end
         endcase
         cos_out[k] = c[31:0];
         sin_out[k] = s[31:0];
      end
   end

   assign out_valid = valid_ff[CORDIC_ITERATIONS];
   assign out_ctx   = ctx_ff[CORDIC_ITERATIONS];

endmodule

@@ rtl/aate_rot.sv @@
// Two-stage plane rotation of three vector pairs by one cosine/sine pair.
module aate_rot import aate_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  ctx_type in_ctx,
   input  vec_type p_in [3],
   input  vec_type q_in [3],
   input  vec_type cos_in,
   input  vec_type sin_in,
   output logic    out_valid,
   output ctx_type out_ctx,
   output vec_type p_out [3],
   output vec_type q_out [3]
);

   logic     valid_ff [2];
   ctx_type  ctx_ff   [2];
   prod_type pc_ff [3];
   prod_type qs_ff [3];
   prod_type qc_ff [3];
   prod_type ps_ff [3];
   vec_type  p_ff  [3];
   vec_type  q_ff  [3];
   vec_type  p_in2 [3];
   vec_type  q_in2 [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
         valid_ff[1] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         valid_ff[1] <= valid_ff[0];
      end
   end

   // Register the four products of each pair
   always_ff @(posedge clock) begin
      if (advance) begin
         ctx_ff[0] <= in_ctx;
         for (int k = 0; k < 3; k++) begin
            pc_ff[k] <= 64'(p_in[k]) * 64'(cos_in);
            qs_ff[k] <= 64'(q_in[k]) * 64'(sin_in);
            qc_ff[k] <= 64'(q_in[k]) * 64'(cos_in);
            ps_ff[k] <= 64'(p_in[k]) * 64'(sin_in);
         end
      end
   end

   // Sum, round half up and drop the 30 fraction bits
   always_comb begin
      logic signed [64:0] sp, sq;
      for (int k = 0; k < 3; k++) begin
         sp = 65'(pc_ff[k]) + 65'(qs_ff[k]) + ROUND_HALF;
         sq = 65'(qc_ff[k]) - 65'(ps_ff[k]) + ROUND_HALF;
         p_in2[k] = sp[61:30];
         q_in2[k] = sq[61:30];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctx_ff[1] <= ctx_ff[0];
         for (int k = 0; k < 3; k++) begin
            p_ff[k] <= p_in2[k];
            q_ff[k] <= q_in2[k];
         end
      end
   end

   assign out_valid = valid_ff[1];
   assign out_ctx   = ctx_ff[1];
   assign p_out     = p_ff;
   assign q_out     = q_ff;

endmodule
